### rtl/irr_pkg.sv
// ============================================================================
// irr_pkg
// Shared types and constants for the image rotate resampler.
// ============================================================================
`default_nettype none

package irr_pkg;

    localparam int MaxWidth  = 512;
    localparam int MaxHeight = 512;
    localparam int FracBits  = 8;
    localparam int PosFrac   = 18;
    localparam int ColW      = $clog2(MaxWidth);
    localparam int RowW      = $clog2(MaxHeight);
    localparam int AddrW     = ColW + RowW;
    localparam int Depth     = MaxWidth * MaxHeight;
    // rotated position: 2^-18 pixel units, wide enough for any coefficient
    localparam int PosW      = 40;
    localparam int ProdW     = 33;

    localparam logic [31:0] Background = 32'h00FF_FFFF;

    localparam logic OpLoad   = 1'b0;
    localparam logic OpRender = 1'b1;

    localparam logic [2:0] RegSin   = 3'd0;
    localparam logic [2:0] RegCos   = 3'd1;
    localparam logic [2:0] RegCx    = 3'd2;
    localparam logic [2:0] RegCy    = 3'd3;
    localparam logic [2:0] RegLastC = 3'd4;
    localparam logic [2:0] RegLastR = 3'd5;
    localparam logic [2:0] RegMode  = 3'd6;

    typedef struct packed {
        logic        opcode;
        logic [8:0]  pos_x;
        logic [8:0]  pos_y;
        logic [31:0] pixel_in;
    } irr_in_t;

    typedef struct packed {
        logic [8:0]  out_x;
        logic [8:0]  out_y;
        logic [31:0] out_pixel;
    } irr_out_t;

    typedef struct packed {
        logic signed [15:0] sin_coef;
        logic signed [15:0] cos_coef;
        logic signed [14:0] pivot_x;
        logic signed [14:0] pivot_y;
        logic [8:0]         last_column;
        logic [8:0]         last_row;
        logic               filter_mode;
    } irr_cfg_t;

    // one neighbour lookup: address and inside-image flag
    typedef struct packed {
        logic [AddrW-1:0] addr;
        logic             in_img;
    } irr_tap_t;

endpackage

`default_nettype wire

### rtl/irr_ram.sv
// ============================================================================
// irr_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ============================================================================
`default_nettype none

module irr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/irr_map.sv
// ============================================================================
// irr_map
// Inverse-rotation of the target position: four register stages producing
// the four neighbour addresses, inside flags and blend fractions.
// ============================================================================
`default_nettype none

module irr_map (
    input  wire logic              aclk,
    input  wire logic              en,
    input  wire irr_pkg::irr_cfg_t cfg,
    input  wire logic [8:0]        pos_x,
    input  wire logic [8:0]        pos_y,
    output irr_pkg::irr_tap_t      tap_tl,
    output irr_pkg::irr_tap_t      tap_tr,
    output irr_pkg::irr_tap_t      tap_bl,
    output irr_pkg::irr_tap_t      tap_br,
    output logic [7:0]             frac_u,
    output logic [7:0]             frac_v
);
    import irr_pkg::*;

    // stage 1: offsets from center
    logic signed [16:0] dx_reg, dy_reg;
    // stage 2: products
    logic signed [ProdW-1:0] xc_reg, ys_reg, xs_reg, yc_reg;
    logic signed [PosW-1:0]  cxo_reg, cyo_reg;
    // stage 3: position
    logic signed [PosW-1:0]  sx_reg, sy_reg;
    // stage 4: taps
    irr_tap_t tl_reg, tr_reg, bl_reg, br_reg;
    logic [7:0] u_reg, v_reg;

    logic signed [PosW-1:0] sx_next, sy_next;
    logic signed [PosW-1:0] lim_x, lim_y;
    logic signed [PosW-1-PosFrac:0] ix, iy, ix1, iy1;
    logic nx_in;
    logic [ColW-1:0] ncol;
    logic [RowW-1:0] nrow;
    irr_tap_t tl_next, tr_next, bl_next, br_next;

    function automatic irr_tap_t make_tap(
        input logic signed [PosW-1-PosFrac:0] c,
        input logic signed [PosW-1-PosFrac:0] r,
        input logic [8:0] lc,
        input logic [8:0] lr
    );
        irr_tap_t t;
        t.in_img = !c[PosW-1-PosFrac] && !r[PosW-1-PosFrac]
                && (c <= $signed({1'b0, lc})) && (r <= $signed({1'b0, lr}))
                && (c < MaxWidth) && (r < MaxHeight);
        t.addr = {r[RowW-1:0], c[ColW-1:0]};
        return t;
    endfunction

    always_comb begin
        sx_next = PosW'(xc_reg) - PosW'(ys_reg) + cxo_reg;
        sy_next = PosW'(xs_reg) + PosW'(yc_reg) + cyo_reg;
        // floor of the position; FracBits of the 18 fraction bits make u, v
        ix  = sx_reg[PosW-1:PosFrac];
        iy  = sy_reg[PosW-1:PosFrac];
        ix1 = ix + 1'b1;
        iy1 = iy + 1'b1;
        lim_x = $signed({{(PosW-9-PosFrac){1'b0}}, cfg.last_column, {PosFrac{1'b0}}});
        lim_y = $signed({{(PosW-9-PosFrac){1'b0}}, cfg.last_row, {PosFrac{1'b0}}});
        tl_next = make_tap(ix, iy, cfg.last_column, cfg.last_row);
        tr_next = make_tap(ix1, iy, cfg.last_column, cfg.last_row);
        bl_next = make_tap(ix, iy1, cfg.last_column, cfg.last_row);
        br_next = make_tap(ix1, iy1, cfg.last_column, cfg.last_row);
        // nearest: nonnegative so floor equals truncation
        nx_in = !sx_reg[PosW-1] && !sy_reg[PosW-1] && sx_reg <= lim_x && sy_reg <= lim_y;
        ncol  = ix[ColW-1:0];
        nrow  = iy[RowW-1:0];
        if (!cfg.filter_mode) begin
            tl_next.in_img = nx_in && (ix < MaxWidth) && (iy < MaxHeight);
            tl_next.addr   = {nrow, ncol};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dx_reg  <= $signed({4'b0, pos_x, 4'b0}) - 17'(cfg.pivot_x);
            dy_reg  <= $signed({4'b0, pos_y, 4'b0}) - 17'(cfg.pivot_y);
            xc_reg  <= ProdW'(dx_reg) * ProdW'(cfg.cos_coef);
            ys_reg  <= ProdW'(dy_reg) * ProdW'(cfg.sin_coef);
            xs_reg  <= ProdW'(dx_reg) * ProdW'(cfg.sin_coef);
            yc_reg  <= ProdW'(dy_reg) * ProdW'(cfg.cos_coef);
            cxo_reg <= PosW'(cfg.pivot_x) <<< 14;
            cyo_reg <= PosW'(cfg.pivot_y) <<< 14;
            sx_reg  <= sx_next;
            sy_reg  <= sy_next;
            tl_reg  <= tl_next;
            tr_reg  <= tr_next;
            bl_reg  <= bl_next;
            br_reg  <= br_next;
            u_reg   <= cfg.filter_mode ? sx_reg[PosFrac-1 -: FracBits] : 8'd0;
            v_reg   <= cfg.filter_mode ? sy_reg[PosFrac-1 -: FracBits] : 8'd0;
        end
    end

    assign tap_tl = tl_reg;
    assign tap_tr = tr_reg;
    assign tap_bl = bl_reg;
    assign tap_br = br_reg;
    assign frac_u = u_reg;
    assign frac_v = v_reg;

endmodule

`default_nettype wire

### rtl/irr_blend.sv
// ============================================================================
// irr_blend
// Bilinear channel blend over two register stages: weights, then products
// and sum. Nearest mode runs with zero fractions, which passes tap one.
// ============================================================================
`default_nettype none

module irr_blend (
    input  wire logic        aclk,
    input  wire logic        en,
    input  wire logic [31:0] p1,
    input  wire logic [31:0] p2,
    input  wire logic [31:0] p3,
    input  wire logic [31:0] p4,
    input  wire logic [7:0]  frac_u,
    input  wire logic [7:0]  frac_v,
    output logic      [31:0] pixel
);
    import irr_pkg::*;

    localparam int WW = 2 * FracBits + 1;

    logic [WW-1:0] w1_reg, w2_reg, w3_reg, w4_reg;
    logic [31:0]   q1_reg, q2_reg, q3_reg, q4_reg;
    logic [31:0]   pix_reg;
    logic [31:0]   pix_next;
    logic [FracBits:0] su, sv;
    logic [WW+9:0] acc;

    always_comb begin
        su = (FracBits+1)'(1 << FracBits) - {1'b0, frac_u};
        sv = (FracBits+1)'(1 << FracBits) - {1'b0, frac_v};
        pix_next = '0;
        for (int c = 0; c < 4; c++) begin
            acc = (WW+10)'(q1_reg[c*8 +: 8]) * (WW+10)'(w1_reg)
                + (WW+10)'(q2_reg[c*8 +: 8]) * (WW+10)'(w2_reg)
                + (WW+10)'(q3_reg[c*8 +: 8]) * (WW+10)'(w3_reg)
                + (WW+10)'(q4_reg[c*8 +: 8]) * (WW+10)'(w4_reg);
            pix_next[c*8 +: 8] = acc[2*FracBits +: 8];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            w1_reg  <= WW'(su) * WW'(sv);
            w2_reg  <= WW'(frac_u) * WW'(sv);
            w3_reg  <= WW'(su) * WW'(frac_v);
            w4_reg  <= WW'(frac_u) * WW'(frac_v);
            q1_reg  <= p1;
            q2_reg  <= p2;
            q3_reg  <= p3;
            q4_reg  <= p4;
            pix_reg <= pix_next;
        end
    end

    assign pixel = pix_reg;

endmodule

`default_nettype wire

### rtl/image_rotate_resampler_unit.sv
// ============================================================================
// image_rotate_resampler_unit
// Rotating image resampler, nearest or bilinear, with four source RAM copies.
// ============================================================================
// Pipeline: nine register stages from input transfer to result valid
//   (mapping 4, RAM 1, tap select 1, blend 2, output 1); no load result.
// Throughput: one item per cycle; the pipeline advances whenever the output
//   register is empty or being taken, so a stalled sink holds every stage.
// Reset: aresetn (synchronous) clears the valid bits and sets the configuration
//   registers to their defaults; the source image is undefined until loaded.
`default_nettype none

module image_rotate_resampler_unit (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire irr_pkg::irr_in_t  s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output irr_pkg::irr_out_t      m_data,
    input  wire logic              cfg_we,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [15:0]       cfg_wdata
);
    import irr_pkg::*;

    localparam int Lat = 8;

    irr_cfg_t cfg_reg;
    logic     adv;
    logic [Lat-1:0] vld_reg;
    logic [8:0] x_reg [Lat];
    logic [8:0] y_reg [Lat];
    logic       out_v_reg;
    irr_out_t   out_reg;
    logic       wr;
    logic [2:0]       ld_v_reg;
    logic [AddrW-1:0] ld_addr_reg [3];
    logic [31:0]      ld_data_reg [3];
    irr_tap_t   tl, tr, bl, br;
    logic [7:0] fu, fv;
    logic [7:0] fu_reg [2], fv_reg [2];
    logic [3:0] in_reg;
    logic [31:0] rd [4];
    logic [31:0] p1, p2, p3, p4, blended;

    assign adv     = !out_v_reg || m_ready;
    assign s_ready = adv;
    // loads write in step with the render reads, so each render sees exactly
    // the loads transferred before it
    assign wr      = ld_v_reg[2] && adv;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{sin_coef: 16'sd0, cos_coef: 16'sd16384, pivot_x: 15'sd4096,
                         pivot_y: 15'sd4096, last_column: 9'd511, last_row: 9'd511,
                         filter_mode: 1'b1};
        end else if (cfg_we) begin
            unique case (cfg_index)
                RegSin:   cfg_reg.sin_coef    <= cfg_wdata;
                RegCos:   cfg_reg.cos_coef    <= cfg_wdata;
                RegCx:    cfg_reg.pivot_x     <= cfg_wdata[14:0];
                RegCy:    cfg_reg.pivot_y     <= cfg_wdata[14:0];
                RegLastC: cfg_reg.last_column <= cfg_wdata[8:0];
                RegLastR: cfg_reg.last_row    <= cfg_wdata[8:0];
                RegMode:  cfg_reg.filter_mode <= cfg_wdata[0];
                default:  ;
            endcase
        end
    end

    // valid bits and coordinates travel beside the datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg   <= '0;
            ld_v_reg  <= '0;
            out_v_reg <= 1'b0;
        end else if (adv) begin
            vld_reg   <= {vld_reg[Lat-2:0], s_valid && s_data.opcode == OpRender};
            ld_v_reg  <= {ld_v_reg[1:0], s_valid && s_data.opcode == OpLoad};
            out_v_reg <= vld_reg[Lat-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            x_reg[0] <= s_data.pos_x;
            y_reg[0] <= s_data.pos_y;
            for (int i = 1; i < Lat; i++) begin
                x_reg[i] <= x_reg[i-1];
                y_reg[i] <= y_reg[i-1];
            end
            ld_addr_reg[0] <= {s_data.pos_y, s_data.pos_x};
            ld_data_reg[0] <= s_data.pixel_in;
            for (int i = 1; i < 3; i++) begin
                ld_addr_reg[i] <= ld_addr_reg[i-1];
                ld_data_reg[i] <= ld_data_reg[i-1];
            end
            out_reg <= '{out_x: x_reg[Lat-1], out_y: y_reg[Lat-1], out_pixel: blended};
            in_reg  <= {br.in_img, bl.in_img, tr.in_img, tl.in_img};
            fu_reg[0] <= fu;
            fv_reg[0] <= fv;
            fu_reg[1] <= fu_reg[0];
            fv_reg[1] <= fv_reg[0];
        end
    end

    irr_map u_map (
        .aclk(aclk), .en(adv), .cfg(cfg_reg),
        .pos_x(s_data.pos_x), .pos_y(s_data.pos_y),
        .tap_tl(tl), .tap_tr(tr), .tap_bl(bl), .tap_br(br),
        .frac_u(fu), .frac_v(fv)
    );

    // four copies of the image, one per neighbour
    irr_ram #(.WIDTH(32), .DEPTH(Depth)) u_ram0 (.aclk(aclk), .we(wr),
        .waddr(ld_addr_reg[2]), .wdata(ld_data_reg[2]),
        .re(adv), .raddr(tl.addr), .rdata(rd[0]));
    irr_ram #(.WIDTH(32), .DEPTH(Depth)) u_ram1 (.aclk(aclk), .we(wr),
        .waddr(ld_addr_reg[2]), .wdata(ld_data_reg[2]),
        .re(adv), .raddr(tr.addr), .rdata(rd[1]));
    irr_ram #(.WIDTH(32), .DEPTH(Depth)) u_ram2 (.aclk(aclk), .we(wr),
        .waddr(ld_addr_reg[2]), .wdata(ld_data_reg[2]),
        .re(adv), .raddr(bl.addr), .rdata(rd[2]));
    irr_ram #(.WIDTH(32), .DEPTH(Depth)) u_ram3 (.aclk(aclk), .we(wr),
        .waddr(ld_addr_reg[2]), .wdata(ld_data_reg[2]),
        .re(adv), .raddr(br.addr), .rdata(rd[3]));

    // background substitution
    assign p1 = in_reg[0] ? rd[0] : Background;
    assign p2 = in_reg[1] ? rd[1] : Background;
    assign p3 = in_reg[2] ? rd[2] : Background;
    assign p4 = in_reg[3] ? rd[3] : Background;

    logic [31:0] p1_reg, p2_reg, p3_reg, p4_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_reg <= p1;
            p2_reg <= p2;
            p3_reg <= p3;
            p4_reg <= p4;
        end
    end

    irr_blend u_blend (
        .aclk(aclk), .en(adv),
        .p1(p1_reg), .p2(p2_reg), .p3(p3_reg), .p4(p4_reg),
        .frac_u(fu_reg[1]), .frac_v(fv_reg[1]), .pixel(blended)
    );

    assign m_valid = out_v_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire

### rtl/irr_checker.sv
// ============================================================================
// irr_checker
// Port-level checks on the resampler's handshakes.
// ============================================================================
`default_nettype none

module irr_checker (
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_valid,
    input wire logic              s_ready,
    input wire irr_pkg::irr_in_t  s_data,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire irr_pkg::irr_out_t m_data
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // input is always taken when output is free
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input blocked with empty output");

    // stalled input holds its payload
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("input changed while stalled");

    // no result right out of reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind image_rotate_resampler_unit irr_checker u_irr_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .s_data(s_data), .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
);

`default_nettype wire
